### rtl/optical_flow_velocity_estimator_macros.svh
// ---------------------------------------------------------------------------
// optical flow velocity estimator assertion macros
// shared concurrent assertion forms, clocked on clk, idle in reset
// ---------------------------------------------------------------------------
`ifndef OPTICAL_FLOW_VELOCITY_ESTIMATOR_MACROS_SVH
`define OPTICAL_FLOW_VELOCITY_ESTIMATOR_MACROS_SVH

// property that must hold in the same cycle
`define OFVE_ASSERT(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define OFVE_ASSERT_NEXT(name, trig, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ofve_pkg.sv
// ---------------------------------------------------------------------------
// ofve_pkg
// shared types, constants and tables of the optical flow velocity estimator
// ---------------------------------------------------------------------------
package ofve_pkg;

	localparam int IN_W   = 96;
	localparam int OUT_W  = 128;
	localparam int CFG_W  = 24;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_QUALITY_THRESHOLD = 2'd0;
	localparam logic [IDX_W-1:0] REG_TILT_LIMIT        = 2'd1;
	localparam logic [IDX_W-1:0] REG_PIXELS_PER_RADIAN = 2'd2;
	localparam logic [IDX_W-1:0] REG_GROUND_PER_PIXEL  = 2'd3;

	localparam logic [7:0]  QUALITY_THRESHOLD_RST = 8'd10;
	localparam logic [14:0] TILT_LIMIT_RST        = 15'd6434;
	localparam logic [19:0] PIXELS_PER_RADIAN_RST = 20'd38400;
	localparam logic [23:0] GROUND_PER_PIXEL_RST  = 24'd117000;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;

	localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

	typedef struct packed {
		logic        start;
		logic [47:0] a;
		logic [31:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic               valid;
		logic signed [33:0] sin;
		logic signed [33:0] cos;
	} cordic_rsp_t;

	// arctan(2^-i) in Q.30
	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] r;
		case (idx)
			5'd0:  r = 30'd843314857;
			5'd1:  r = 30'd497837830;
			5'd2:  r = 30'd263043837;
			5'd3:  r = 30'd133525159;
			5'd4:  r = 30'd67021687;
			5'd5:  r = 30'd33543515;
			5'd6:  r = 30'd16775851;
			5'd7:  r = 30'd8388438;
			5'd8:  r = 30'd4194283;
			5'd9:  r = 30'd2097150;
			5'd10: r = 30'd1048576;
			5'd11: r = 30'd524288;
			5'd12: r = 30'd262144;
			5'd13: r = 30'd131072;
			5'd14: r = 30'd65536;
			5'd15: r = 30'd32768;
			5'd16: r = 30'd16384;
			5'd17: r = 30'd8192;
			5'd18: r = 30'd4096;
			5'd19: r = 30'd2048;
			5'd20: r = 30'd1024;
			5'd21: r = 30'd512;
			5'd22: r = 30'd256;
			5'd23: r = 30'd128;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/ofve_mul.sv
// ---------------------------------------------------------------------------
// ofve_mul
// shared unsigned multiplier, 48 by 32 bits, one 16-bit digit per cycle
// ---------------------------------------------------------------------------
module ofve_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  ofve_pkg::mul_req_t req,
	output ofve_pkg::mul_rsp_t rsp
);
	import ofve_pkg::*;

	logic [47:0] a_q;
	logic [31:0] b_q;
	logic [63:0] acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [47:0] pp;
	logic [63:0] pp_sh;

	assign pp = a_q[15:0] * b_q;

	always_comb begin
		case (cnt_q)
			2'd0: pp_sh = {16'd0, pp};
			2'd1: pp_sh = {pp, 16'd0};
			2'd2: pp_sh = {pp[31:0], 32'd0};
			default: pp_sh = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= 64'd0;
		end else if (busy_q) begin
			a_q   <= a_q >> 16;
			acc_q <= acc_q + pp_sh;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

### rtl/ofve_cordic.sv
// ---------------------------------------------------------------------------
// ofve_cordic
// iterative rotation-mode cordic giving sine and cosine of the heading
// ---------------------------------------------------------------------------
module ofve_cordic #(
	parameter int CORDIC_STEPS = ofve_pkg::CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [15:0]   yaw,
	output ofve_pkg::cordic_rsp_t rsp
);
	import ofve_pkg::*;

	localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

	logic signed [33:0] x_q, y_q, z_q;
	logic [4:0]         i_q;
	logic               busy_q, valid_q, flip_q;
	logic signed [33:0] z0, tx, ty, at;

	assign z0 = {yaw[15], yaw, 17'd0};
	assign tx = y_q >>> i_q;
	assign ty = x_q >>> i_q;
	assign at = {4'd0, atan_q30(i_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			i_q     <= 5'd0;
		end else if (start) begin
			busy_q  <= 1'b1;
			valid_q <= 1'b0;
			i_q     <= 5'd0;
		end else if (busy_q) begin
			i_q <= i_q + 5'd1;
			if (i_q == LAST) begin
				busy_q  <= 1'b0;
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_K;
			y_q <= 34'sd0;
			// fold headings beyond a quarter turn, negate the result later
			if (z0 > HALF_PI_Q30) begin
				z_q    <= z0 - PI_Q30;
				flip_q <= 1'b1;
			end else if (z0 < -HALF_PI_Q30) begin
				z_q    <= z0 + PI_Q30;
				flip_q <= 1'b1;
			end else begin
				z_q    <= z0;
				flip_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - tx;
				y_q <= y_q + ty;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + tx;
				y_q <= y_q - ty;
				z_q <= z_q + at;
			end
		end
	end

	assign rsp.valid = valid_q;
	assign rsp.sin   = flip_q ? -y_q : y_q;
	assign rsp.cos   = flip_q ? -x_q : x_q;

endmodule

### rtl/optical_flow_velocity_estimator.sv
// ---------------------------------------------------------------------------
// optical_flow_velocity_estimator
// tilt compensated ground velocity from one optical flow item
// ---------------------------------------------------------------------------
// One item is taken at a time. An item that fails the quality and tilt gate
// goes straight to S_FIN and is answered with the held velocities.
// An item that passes runs ten products through one shared 16x32 multiply
// unit. Each product passes through issue, three digit steps and the step
// that sees the finished product. A rounding step and an output step follow,
// and the next item is taken once the result is in the output register.
// The cordic for the heading runs its CORDIC_STEPS iterations alongside the
// first products, and the rotation products wait for its sine and cosine.
// A finished result sits in the output register; while it waits the next
// item is taken, and that item's result is held in the core until the output
// register is free.
module optical_flow_velocity_estimator #(
	parameter int CORDIC_STEPS = ofve_pkg::CORDIC_STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// delta_x, delta_y, quality, roll_angle, pitch_angle, yaw_angle, height
	input  logic [ofve_pkg::IN_W-1:0]    s_tdata,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// vel_x, vel_y, vel_lon, vel_lat
	output logic [ofve_pkg::OUT_W-1:0]   m_tdata,
	// updated
	output logic                         m_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic                         cfg_we,
	input  logic [ofve_pkg::IDX_W-1:0]   cfg_index,
	input  logic [ofve_pkg::CFG_W-1:0]   cfg_data
);
	import ofve_pkg::*;
	`include "optical_flow_velocity_estimator_macros.svh"

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ISSUE = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_ROUND = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	localparam logic [3:0] OP_CX  = 4'd0;
	localparam logic [3:0] OP_CY  = 4'd1;
	localparam logic [3:0] OP_MX  = 4'd2;
	localparam logic [3:0] OP_VX  = 4'd3;
	localparam logic [3:0] OP_MY  = 4'd4;
	localparam logic [3:0] OP_VY  = 4'd5;
	localparam logic [3:0] OP_LXS = 4'd6;
	localparam logic [3:0] OP_LYC = 4'd7;
	localparam logic [3:0] OP_AYS = 4'd8;
	localparam logic [3:0] OP_AXC = 4'd9;

	logic [2:0]  state_q;
	logic [3:0]  op_q;

	logic [7:0]  qthr_q;
	logic [14:0] tilt_q;
	logic [19:0] ppr_q;
	logic [23:0] gpp_q;

	logic [15:0] last_roll_q, last_pitch_q;
	logic [23:0] last_height_q;
	logic [31:0] vx_q, vy_q, vlon_q, vlat_q;

	logic [7:0]         dx_q, dy_q;
	logic [16:0]        dr_q, dp_q;
	logic [24:0]        hsum_q;
	logic [38:0]        cx_q, cy_q;
	logic [47:0]        m_q;
	logic               upd_q;
	logic signed [65:0] lon_q, lat_q;

	logic [7:0]  in_dx, in_dy, in_q;
	logic [15:0] in_roll, in_pitch, in_yaw;
	logic [23:0] in_h, h_use;
	logic [16:0] roll_w, pitch_w, ar, ap;
	logic        gate, acc_in;

	mul_req_t    mreq;
	mul_rsp_t    mrsp;
	cordic_rsp_t crsp;

	logic [16:0] dr_abs, dp_abs;
	logic [24:0] hs_abs;
	logic [38:0] cx_abs, cy_abs;
	logic [31:0] vx_abs, vy_abs, s_abs, c_abs;
	logic [33:0] s_mag, c_mag;
	logic        term_neg;
	logic signed [65:0] term;
	logic        rot_ready;
	logic        out_load;

	function automatic logic [31:0] sat_mag(input logic pos, input logic [49:0] m);
		logic [31:0] r;
		if (pos)
			r = (m > 50'd2147483647) ? 32'h7FFF_FFFF : m[31:0];
		else
			r = (m > 50'd2147483648) ? 32'h8000_0000 : (32'd0 - m[31:0]);
		return r;
	endfunction

	function automatic logic [31:0] rot_sat(input logic signed [65:0] a);
		logic signed [65:0] t;
		logic [31:0]        r;
		t = (a + 66'sd536870912) >>> 30;
		if (t > 66'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (t < -66'sd2147483648)
			r = 32'h8000_0000;
		else
			r = t[31:0];
		return r;
	endfunction

	assign in_dx    = s_tdata[7:0];
	assign in_dy    = s_tdata[15:8];
	assign in_q     = s_tdata[23:16];
	assign in_roll  = s_tdata[39:24];
	assign in_pitch = s_tdata[55:40];
	assign in_yaw   = s_tdata[71:56];
	assign in_h     = s_tdata[95:72];

	assign roll_w  = {in_roll[15], in_roll};
	assign pitch_w = {in_pitch[15], in_pitch};
	assign ar = in_roll[15] ? (17'd0 - roll_w) : roll_w;
	assign ap = in_pitch[15] ? (17'd0 - pitch_w) : pitch_w;
	assign gate = (in_q >= qthr_q) && (ar <= {2'b00, tilt_q}) && (ap <= {2'b00, tilt_q});
	// negative altitude counts as ground level, but only on an update
	assign h_use = (gate && in_h[23]) ? 24'd0 : in_h;

	assign s_tready = (state_q == S_IDLE);
	assign acc_in   = s_tvalid && s_tready;
	assign out_load = (state_q == S_FIN) && (!m_tvalid || m_tready);

	assign dr_abs = dr_q[16] ? (17'd0 - dr_q) : dr_q;
	assign dp_abs = dp_q[16] ? (17'd0 - dp_q) : dp_q;
	assign hs_abs = hsum_q[24] ? (25'd0 - hsum_q) : hsum_q;
	assign cx_abs = cx_q[38] ? (39'd0 - cx_q) : cx_q;
	assign cy_abs = cy_q[38] ? (39'd0 - cy_q) : cy_q;
	assign vx_abs = vx_q[31] ? (32'd0 - vx_q) : vx_q;
	assign vy_abs = vy_q[31] ? (32'd0 - vy_q) : vy_q;
	assign s_mag  = crsp.sin[33] ? (34'd0 - crsp.sin) : crsp.sin;
	assign c_mag  = crsp.cos[33] ? (34'd0 - crsp.cos) : crsp.cos;
	assign s_abs  = s_mag[31:0];
	assign c_abs  = c_mag[31:0];

	assign rot_ready = (op_q < OP_LXS) || crsp.valid;

	// operand select for the shared multiplier
	always_comb begin
		mreq.start = (state_q == S_ISSUE) && rot_ready;
		mreq.a     = 48'd0;
		mreq.b     = 32'd0;
		term_neg   = 1'b0;
		case (op_q)
			OP_CX: begin
				mreq.a = {28'd0, ppr_q};
				mreq.b = {15'd0, dr_abs};
			end
			OP_CY: begin
				mreq.a = {28'd0, ppr_q};
				mreq.b = {15'd0, dp_abs};
			end
			OP_MX: begin
				mreq.a = {10'd0, cx_abs[37:0]};
				mreq.b = {8'd0, hs_abs[23:0]};
			end
			OP_MY: begin
				mreq.a = {10'd0, cy_abs[37:0]};
				mreq.b = {8'd0, hs_abs[23:0]};
			end
			OP_VX, OP_VY: begin
				mreq.a = m_q;
				mreq.b = {8'd0, gpp_q};
			end
			OP_LXS: begin
				mreq.a   = {16'd0, vx_abs};
				mreq.b   = s_abs;
				term_neg = vx_q[31] ^ crsp.sin[33];
			end
			OP_LYC: begin
				mreq.a   = {16'd0, vy_abs};
				mreq.b   = c_abs;
				term_neg = vy_q[31] ^ crsp.cos[33];
			end
			OP_AYS: begin
				mreq.a   = {16'd0, vy_abs};
				mreq.b   = s_abs;
				term_neg = vy_q[31] ^ crsp.sin[33];
			end
			OP_AXC: begin
				mreq.a   = {16'd0, vx_abs};
				mreq.b   = c_abs;
				term_neg = !(vx_q[31] ^ crsp.cos[33]);
			end
			default: begin
				mreq.a = 48'd0;
				mreq.b = 32'd0;
			end
		endcase
	end

	assign term = term_neg ? -$signed({2'b00, mrsp.prod}) : $signed({2'b00, mrsp.prod});

	ofve_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	ofve_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (acc_in && gate),
		.yaw    (in_yaw),
		.rsp    (crsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qthr_q <= QUALITY_THRESHOLD_RST;
			tilt_q <= TILT_LIMIT_RST;
			ppr_q  <= PIXELS_PER_RADIAN_RST;
			gpp_q  <= GROUND_PER_PIXEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUALITY_THRESHOLD: qthr_q <= cfg_data[7:0];
				REG_TILT_LIMIT:        tilt_q <= cfg_data[14:0];
				REG_PIXELS_PER_RADIAN: ppr_q  <= cfg_data[19:0];
				REG_GROUND_PER_PIXEL:  gpp_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_CX;
			last_roll_q   <= 16'd0;
			last_pitch_q  <= 16'd0;
			last_height_q <= 24'd0;
			vx_q          <= 32'd0;
			vy_q          <= 32'd0;
			vlon_q        <= 32'd0;
			vlat_q        <= 32'd0;
			upd_q         <= 1'b0;
			m_tvalid      <= 1'b0;
		end else begin
			if (out_load)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						upd_q         <= gate;
						op_q          <= OP_CX;
						last_roll_q   <= in_roll;
						last_pitch_q  <= in_pitch;
						last_height_q <= h_use;
						state_q       <= gate ? S_ISSUE : S_FIN;
					end
				end
				S_ISSUE: begin
					if (rot_ready)
						state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (mrsp.done) begin
						case (op_q)
							OP_VX: vx_q <= sat_mag(cx_q[38] ^ hsum_q[24],
								50'((mrsp.prod + 64'd8192) >> 14));
							OP_VY: vy_q <= sat_mag(cy_q[38] ^ hsum_q[24],
								50'((mrsp.prod + 64'd8192) >> 14));
							default: ;
						endcase
						if (op_q == OP_AXC) begin
							state_q <= S_ROUND;
						end else begin
							op_q    <= op_q + 4'd1;
							state_q <= S_ISSUE;
						end
					end
				end
				S_ROUND: begin
					vlon_q  <= rot_sat(lon_q);
					vlat_q  <= rot_sat(lat_q);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers of the item in flight
	always_ff @(posedge clk) begin
		if (acc_in) begin
			dx_q   <= in_dx;
			dy_q   <= in_dy;
			dr_q   <= roll_w - {last_roll_q[15], last_roll_q};
			dp_q   <= pitch_w - {last_pitch_q[15], last_pitch_q};
			hsum_q <= {h_use[23], h_use} + {last_height_q[23], last_height_q};
			lon_q  <= 66'sd0;
			lat_q  <= 66'sd0;
		end else if (state_q == S_WAIT && mrsp.done) begin
			case (op_q)
				OP_CX: cx_q <= {{10{dx_q[7]}}, dx_q, 21'd0}
					- (dr_q[16] ? (39'd0 - mrsp.prod[38:0]) : mrsp.prod[38:0]);
				OP_CY: cy_q <= {{10{dy_q[7]}}, dy_q, 21'd0}
					+ (dp_q[16] ? (39'd0 - mrsp.prod[38:0]) : mrsp.prod[38:0]);
				OP_MX, OP_MY: m_q <= 48'((mrsp.prod + 64'd8388608) >> 24);
				OP_LXS, OP_LYC: lon_q <= lon_q + term;
				OP_AYS, OP_AXC: lat_q <= lat_q + term;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!m_tvalid || m_tready)) begin
			m_tdata <= {vlat_q, vlon_q, vy_q, vx_q};
			m_tuser <= upd_q;
		end
	end

	`OFVE_ASSERT_NEXT(a_gate_fail_skips, acc_in && !gate, state_q == S_FIN,
		"gated-off item did not go straight to the result")
	`OFVE_ASSERT(a_mul_done_in_wait, mrsp.done |-> state_q == S_WAIT,
		"multiplier finished outside of a wait step")
	`OFVE_ASSERT(a_rot_after_cordic, mreq.start && op_q >= OP_LXS |-> crsp.valid,
		"rotation product issued before sine and cosine were ready")
	`OFVE_ASSERT_NEXT(a_fin_loads_out, state_q == S_FIN && (!m_tvalid || m_tready),
		m_tvalid && state_q == S_IDLE, "finished item not placed in output register")

endmodule

### sim/optical_flow_velocity_estimator_tb.sv
// ---------------------------------------------------------------------------
// optical_flow_velocity_estimator_tb
// drives flow samples through the estimator and checks every velocity
// result against a cycle-free predictor, with register changes between
// phases, random idling on both sides and one long output stall
// ---------------------------------------------------------------------------
module optical_flow_velocity_estimator_tb;
	import ofve_pkg::*;

	typedef struct packed {
		logic signed [23:0] height;
		logic signed [15:0] yaw;
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
		logic [7:0]         quality;
		logic signed [7:0]  dy;
		logic signed [7:0]  dx;
	} flow_sample_t;

	typedef struct packed {
		logic signed [31:0] lat;
		logic signed [31:0] lon;
		logic signed [31:0] vy;
		logic signed [31:0] vx;
	} velocity_t;

	typedef struct {
		velocity_t vel;
		logic      upd;
	} velocity_result_t;

	class velocity_scoreboard;
		logic [7:0]  q_thr;
		logic [14:0] tilt_lim;
		logic [19:0] ppr;
		logic [23:0] gpp;
		longint old_roll, old_pitch, old_height;
		longint hx, hy, hlon, hlat;
		velocity_result_t pending[$];
		int errors;
		int updates;

		function new();
			q_thr = QUALITY_THRESHOLD_RST;
			tilt_lim = TILT_LIMIT_RST;
			ppr = PIXELS_PER_RADIAN_RST;
			gpp = GROUND_PER_PIXEL_RST;
			old_roll = 0; old_pitch = 0; old_height = 0;
			hx = 0; hy = 0; hlon = 0; hlat = 0;
			errors = 0;
			updates = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_QUALITY_THRESHOLD: q_thr = v[7:0];
				REG_TILT_LIMIT:        tilt_lim = v[14:0];
				REG_PIXELS_PER_RADIAN: ppr = v[19:0];
				REG_GROUND_PER_PIXEL:  gpp = v[23:0];
				default: ;
			endcase
		endfunction

		// arithmetic shift is a floor divide on longint
		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint ground_speed(longint change, longint hsum);
			longint unsigned mc, ms, m;
			if (change == 0 || hsum == 0) return 0;
			mc = change < 0 ? -change : change;
			ms = hsum < 0 ? -hsum : hsum;
			m = (mc * ms + (64'd1 << 23)) >> 24;
			m = (m * gpp + (64'd1 << 13)) >> 14;
			if ((change < 0) != (hsum < 0))
				return m > 64'd2147483647 ? 64'sd2147483647 : longint'(m);
			return m > 64'd2147483648 ? -64'sd2147483648 : -longint'(m);
		endfunction

		function void heading_sin_cos(longint yaw, output longint s, output longint c);
			longint z, x, y, tx, ty;
			bit flip;
			z = yaw * 131072;
			x = CORDIC_K;
			y = 0;
			flip = 0;
			if (z > HALF_PI_Q30) begin
				z -= PI_Q30; flip = 1;
			end else if (z < -HALF_PI_Q30) begin
				z += PI_Q30; flip = 1;
			end
			for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_ENTRIES; i++) begin
				tx = y >>> i;
				ty = x >>> i;
				if (z >= 0) begin
					x -= tx; y += ty; z -= longint'(atan_q30(5'(i)));
				end else begin
					x += tx; y -= ty; z += longint'(atan_q30(5'(i)));
				end
			end
			s = flip ? -y : y;
			c = flip ? -x : x;
		endfunction

		function void note_sample(flow_sample_t smp);
			longint roll, pitch, h, cx, cy, s, c;
			velocity_result_t r;
			bit upd;
			roll = smp.roll; pitch = smp.pitch; h = smp.height;
			upd = smp.quality >= q_thr && (roll < 0 ? -roll : roll) <= tilt_lim
				&& (pitch < 0 ? -pitch : pitch) <= tilt_lim;
			if (upd) begin
				if (h < 0) h = 0;
				cx = longint'(smp.dx) * 2097152 - (roll - old_roll) * longint'(ppr);
				cy = longint'(smp.dy) * 2097152 + (pitch - old_pitch) * longint'(ppr);
				hx = ground_speed(cx, h + old_height);
				hy = ground_speed(cy, h + old_height);
				heading_sin_cos(smp.yaw, s, c);
				hlon = sat32((hx * s + hy * c + (64'sd1 << 29)) >>> 30);
				hlat = sat32((hy * s - hx * c + (64'sd1 << 29)) >>> 30);
				updates++;
			end
			old_roll = roll; old_pitch = pitch; old_height = h;
			r.vel.vx = hx[31:0]; r.vel.vy = hy[31:0];
			r.vel.lon = hlon[31:0]; r.vel.lat = hlat[31:0];
			r.upd = upd;
			pending.push_back(r);
		endfunction

		function void check_result(velocity_t got, logic got_upd);
			velocity_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.vx !== e.vel.vx) begin
				$display("%0t: vel_x expected %0d actual %0d", $time, e.vel.vx, got.vx);
				errors++;
			end
			if (got.vy !== e.vel.vy) begin
				$display("%0t: vel_y expected %0d actual %0d", $time, e.vel.vy, got.vy);
				errors++;
			end
			if (got.lon !== e.vel.lon) begin
				$display("%0t: vel_lon expected %0d actual %0d", $time, e.vel.lon, got.lon);
				errors++;
			end
			if (got.lat !== e.vel.lat) begin
				$display("%0t: vel_lat expected %0d actual %0d", $time, e.vel.lat, got.lat);
				errors++;
			end
			if (got_upd !== e.upd) begin
				$display("%0t: updated expected %0b actual %0b", $time, e.upd, got_upd);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tvalid;
	logic m_tready = 0;
	logic cfg_we = 0;
	logic [IDX_W-1:0] cfg_index = REG_QUALITY_THRESHOLD;
	logic [CFG_W-1:0] cfg_data = '0;

	velocity_scoreboard sb = new();
	bit calm = 0;
	bit hold_off = 0;
	int idle_cycles = 0;
	int samples_sent = 0;

	always #5 clk = ~clk;

	optical_flow_velocity_estimator dut (.*);

	// output side: random stalls, plus one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(velocity_t'(m_tdata), m_tuser);
			m_tready <= !hold_off && (calm || $urandom_range(0, 3) != 0);
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("optical_flow_velocity_estimator: mismatch");
			$finish;
		end
	end

	// valid stays up between back-to-back items unless a random gap drops it, drain takes it down
	task automatic send_sample(flow_sample_t smp);
		if (!calm && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tdata <= smp;
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(smp);
		samples_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic flow_sample_t rand_sample(int tilt_span, int q_low);
		flow_sample_t s;
		s.dx = 8'($urandom);
		s.dy = 8'($urandom);
		s.quality = 8'($urandom_range(q_low, 255));
		s.roll = 16'($urandom_range(0, 2 * tilt_span) - tilt_span);
		s.pitch = 16'($urandom_range(0, 2 * tilt_span) - tilt_span);
		s.yaw = 16'($urandom);
		s.height = $urandom_range(0, 9) == 0 ? 24'($urandom)
			: 24'($urandom_range(0, 200000));
		return s;
	endfunction

	task automatic directed_samples();
		flow_sample_t s;
		s = '{height: 24'sd25600, yaw: 16'sd0, pitch: 16'sd0, roll: 16'sd0,
			quality: 8'd255, dy: 8'sd0, dx: 8'sd0};
		send_sample(s);
		s.dx = 8'sd127; s.dy = -8'sd128; send_sample(s);
		s.dx = -8'sd128; s.dy = 8'sd127; s.yaw = 16'sh7fff; send_sample(s);
		s.yaw = -16'sh8000; send_sample(s);
		s.yaw = 16'sd12868; send_sample(s);
		s.yaw = -16'sd12868; send_sample(s);
		s.yaw = 16'sd12869; send_sample(s);
		s.quality = 8'd9; send_sample(s);
		s.quality = 8'd10; send_sample(s);
		s.roll = 16'sd6434; s.pitch = -16'sd6434; send_sample(s);
		s.roll = 16'sd6435; send_sample(s);
		s.roll = -16'sh8000; send_sample(s);
		s.roll = 16'sd0; s.pitch = -16'sh8000; send_sample(s);
		s.pitch = 16'sd0; s.height = -24'sd1000; send_sample(s);
		s.quality = 8'd0; s.height = -24'sd1000; send_sample(s);
		s.quality = 8'd200; s.height = 24'sh7fffff; send_sample(s);
		s.height = 24'sh7fffff; s.dx = 8'sd127; s.roll = -16'sd6434; send_sample(s);
		s.height = -24'sh800000; send_sample(s);
		s.quality = 8'd0; s.height = -24'sh800000; send_sample(s);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed_samples();
		drain();

		// extremes of every register, including zero factors
		write_reg(REG_QUALITY_THRESHOLD, 24'd0);
		write_reg(REG_TILT_LIMIT, 24'h007fff);
		write_reg(REG_PIXELS_PER_RADIAN, 24'd0);
		write_reg(REG_GROUND_PER_PIXEL, 24'hffffff);
		repeat (60) send_sample(rand_sample(32767, 0));
		drain();
		write_reg(REG_PIXELS_PER_RADIAN, 24'h0fffff);
		write_reg(REG_GROUND_PER_PIXEL, 24'd0);
		repeat (40) send_sample(rand_sample(32767, 0));
		drain();
		write_reg(REG_QUALITY_THRESHOLD, 24'd255);
		write_reg(REG_TILT_LIMIT, 24'd0);
		write_reg(REG_GROUND_PER_PIXEL, 24'hffffff);
		repeat (40) send_sample(rand_sample(100, 200));
		drain();

		// long output hold-off while samples keep coming
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			repeat (6) send_sample(rand_sample(32767, 0));
		join
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_QUALITY_THRESHOLD, 24'($urandom_range(0, 40)));
			write_reg(REG_TILT_LIMIT, 24'($urandom_range(2000, 32767)));
			write_reg(REG_PIXELS_PER_RADIAN, 24'($urandom_range(0, 20'hfffff)));
			write_reg(REG_GROUND_PER_PIXEL, 24'($urandom_range(0, 24'hffffff)));
			if (ph == 3) calm = 1;
			repeat (160) send_sample(rand_sample(ph == 0 ? 32767 : 8000, 0));
			drain();
		end

		$display("covered %0d samples, %0d updates, register extremes and zero factors",
			samples_sent, sb.updates);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("optical_flow_velocity_estimator: match");
		else
			$display("optical_flow_velocity_estimator: mismatch");
		$finish;
	end
endmodule
